[rtl/wpm_pkg.sv]
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared types and constants of the WAV PCM16 parser with mono downmix.
// ----------------------------------------------------------------------------
package wpm_pkg;

    typedef enum logic [3:0] {
        PH_RIFF,
        PH_RSIZE,
        PH_WAVE,
        PH_ID,
        PH_SIZE,
        PH_FMT,
        PH_SKIP,
        PH_DATA,
        PH_IDLE
    } wpm_phase_t;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_FINISH = 2'd1,
        KIND_ERROR  = 2'd2
    } wpm_kind_t;

    typedef enum logic [2:0] {
        ERR_NOT_RIFF        = 3'd0,
        ERR_NOT_WAVE        = 3'd1,
        ERR_DATA_BEFORE_FMT = 3'd2,
        ERR_NOT_PCM         = 3'd3,
        ERR_NOT_16BIT       = 3'd4,
        ERR_BAD_CHANNELS    = 3'd5,
        ERR_TRUNCATED       = 3'd6
    } wpm_err_t;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [15:0] FORMAT_PCM  = 16'd1;
    localparam logic [15:0] BITS_16     = 16'd16;
    localparam logic [15:0] SIGN_FLIP   = 16'h8000;

    localparam int QUEUE_DEPTH = 2;

    // results caused by one accepted word: an optional sample, then an
    // optional finish or error
    typedef struct packed {
        logic              sample_v;
        logic signed [15:0] sample;
        logic              tail_v;
        logic              tail_err;
        wpm_err_t          code;
        logic [31:0]       rate;
        logic [1:0]        channels;
    } wpm_entry_t;

endpackage

[rtl/wpm_if.sv]
// ----------------------------------------------------------------------------
// wpm_if
// Valid/ready channels of the WAV parser: file bytes in, results out.
// ----------------------------------------------------------------------------
interface wpm_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface wpm_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         result_kind;
    logic signed [15:0] mono_sample;
    logic [2:0]         error_code;
    logic [31:0]        sample_rate_out;
    logic [1:0]         channel_count;
    logic               last_in_run;

    modport source (output valid, output result_kind, output mono_sample,
                    output error_code, output sample_rate_out, output channel_count,
                    output last_in_run, input ready);
    modport sink   (input valid, input result_kind, input mono_sample,
                    input error_code, input sample_rate_out, input channel_count,
                    input last_in_run, output ready);
endinterface

[rtl/wav_pcm16_parser_mono_downmix.sv]
// ----------------------------------------------------------------------------
// wav_pcm16_parser_mono_downmix
// WAV byte stream parser that emits 16-bit PCM audio as mono Q1.15 samples.
// ----------------------------------------------------------------------------
// Channels: wav takes one file byte per word with end_of_file on the final
// byte; result gives sample, finished and error words, last_in_run marking
// the last word caused by a byte.
// Throughput: one byte per cycle while the queue has room. A byte that
// causes two results (a sample and a finish or truncation error) is sent
// as two words by the output register, which sends one result word per
// cycle while result.ready is high; a short queue absorbs the extra word.
// Path: a result word is written into the queue as its byte is taken, then
// loaded into the output register; the second word follows the first.
// Reset: the parser expects a RIFF tag, the queue and output register are
// empty. A byte with end_of_file also returns the parser to that state.
// Stall: when result.ready is low the output register holds its word, the
// queue fills, and wav.ready drops once the queue is full.
// ----------------------------------------------------------------------------
module wav_pcm16_parser_mono_downmix #(
    parameter int QDEPTH = wpm_pkg::QUEUE_DEPTH  // 2 or more
) (
    input  logic          clk,
    input  logic          rst_n,
    wpm_byte_if.sink      wav,
    wpm_result_if.source  result
);
    import wpm_pkg::*;

    logic       q_full, push, pop, head_valid;
    wpm_entry_t push_data, head_data;

    wpm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .wav       (wav),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    wpm_queue #(.DEPTH(QDEPTH)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    wpm_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head_data),
        .pop        (pop),
        .result     (result)
    );

endmodule

[rtl/wpm_front.sv]
// ----------------------------------------------------------------------------
// wpm_front
// Byte parser: walks RIFF chunks, parses fmt, decodes samples, queues results.
// ----------------------------------------------------------------------------
module wpm_front (
    input  logic                clk,
    input  logic                rst_n,
    wpm_byte_if.sink            wav,
    input  logic                q_full,
    output logic                push,
    output wpm_pkg::wpm_entry_t push_data
);
    import wpm_pkg::*;

    localparam logic [3:0] TAG_LAST = 4'd3;
    localparam logic [3:0] FMT_LAST = 4'd15;

    wpm_phase_t  phase_reg, phase_next, phase_parse;
    logic [3:0]  cnt_reg;
    logic [31:0] tag_reg;
    logic [32:0] len_reg;
    logic [15:0] fmtc_reg, chan_reg, bits_reg;
    logic [31:0] rate_reg;
    logic        fmt_seen_reg;
    logic [7:0]  low_reg;
    logic [15:0] left_reg;
    logic        half_reg;

    logic        accept, eof;
    logic [7:0]  b;
    logic [31:0] tag_new;
    logic [32:0] len_full, size_skip, fmt_skip;
    logic [15:0] smp, avg;
    logic [16:0] avg_sum;
    logic        tag_end, fmt_end;
    logic        fail, finish, trunc, sample_v;
    wpm_err_t    fail_code;
    logic [15:0] sample_val;

    assign wav.ready = !q_full;
    assign accept    = wav.valid && wav.ready;
    assign b         = wav.data_byte;
    assign eof       = wav.end_of_file;

    assign tag_new   = {tag_reg[23:0], b};
    assign len_full  = {1'b0, b, len_reg[23:0]};
    // chunk size plus pad byte, may carry into bit 32
    assign size_skip = len_full + {32'd0, len_full[0]};
    assign fmt_skip  = ((len_reg > 33'd16) ? (len_reg - 33'd16) : 33'd0)
                     + {32'd0, len_reg[0]};
    assign smp       = {b, low_reg};
    // offset binary sum then halve gives floor of the average
    assign avg_sum   = {1'b0, left_reg ^ SIGN_FLIP} + {1'b0, smp ^ SIGN_FLIP};
    assign avg       = avg_sum[16:1] ^ SIGN_FLIP;
    assign tag_end   = (cnt_reg == TAG_LAST);
    assign fmt_end   = (cnt_reg == FMT_LAST);

    // events of the current word
    always_comb
    begin
        fail       = 1'b0;
        fail_code  = ERR_NOT_RIFF;
        finish     = 1'b0;
        sample_v   = 1'b0;
        sample_val = smp;
        unique case (phase_reg)
            PH_RIFF:
            begin
                if (tag_end && tag_new != TAG_RIFF)
                begin
                    fail      = 1'b1;
                    fail_code = ERR_NOT_RIFF;
                end
            end
            PH_WAVE:
            begin
                if (tag_end && tag_new != TAG_WAVE)
                begin
                    fail      = 1'b1;
                    fail_code = ERR_NOT_WAVE;
                end
            end
            PH_SIZE:
            begin
                if (tag_end && tag_reg == TAG_DATA)
                begin
                    priority if (!fmt_seen_reg)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_DATA_BEFORE_FMT;
                    end
                    else if (fmtc_reg != FORMAT_PCM)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_NOT_PCM;
                    end
                    else if (bits_reg != BITS_16)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_NOT_16BIT;
                    end
                    else if (chan_reg == 16'd0 || chan_reg > 16'd2)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_BAD_CHANNELS;
                    end
                    else if (len_full[32:1] == 32'd0)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        finish = 1'b0;
                    end
                end
            end
            PH_DATA:
            begin
                if (cnt_reg[0])
                begin
                    if (chan_reg == 16'd1)
                    begin
                        sample_v = 1'b1;
                    end
                    else if (half_reg)
                    begin
                        sample_v   = 1'b1;
                        sample_val = avg;
                    end
                end
                if (len_reg == 33'd1)
                begin
                    finish = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // next phase
    always_comb
    begin
        phase_parse = phase_reg;
        unique case (phase_reg)
            PH_RIFF:  if (tag_end) phase_parse = fail ? PH_IDLE : PH_RSIZE;
            PH_RSIZE: if (tag_end) phase_parse = PH_WAVE;
            PH_WAVE:  if (tag_end) phase_parse = fail ? PH_IDLE : PH_ID;
            PH_ID:    if (tag_end) phase_parse = PH_SIZE;
            PH_SIZE:
            begin
                if (tag_end)
                begin
                    priority if (tag_reg == TAG_FMT)
                        phase_parse = PH_FMT;
                    else if (tag_reg == TAG_DATA)
                        phase_parse = (fail || finish) ? PH_IDLE : PH_DATA;
                    else
                        phase_parse = (size_skip == 33'd0) ? PH_ID : PH_SKIP;
                end
            end
            PH_FMT:   if (fmt_end) phase_parse = (fmt_skip == 33'd0) ? PH_ID : PH_SKIP;
            PH_SKIP:  if (len_reg <= 33'd1) phase_parse = PH_ID;
            PH_DATA:  if (finish) phase_parse = PH_IDLE;
            PH_IDLE:  phase_parse = PH_IDLE;
            default:  phase_parse = PH_IDLE;
        endcase
        phase_next = eof ? PH_RIFF : phase_parse;
    end

    assign trunc = eof && (phase_parse != PH_IDLE);

    always_comb
    begin
        push_data.sample_v = sample_v;
        push_data.sample   = sample_val;
        push_data.tail_v   = fail || finish || trunc;
        push_data.tail_err = fail || trunc;
        push_data.code     = fail ? fail_code : (trunc ? ERR_TRUNCATED : ERR_NOT_RIFF);
        push_data.rate     = finish ? rate_reg : 32'd0;
        push_data.channels = finish ? chan_reg[1:0] : 2'd0;
    end

    assign push = accept && (sample_v || fail || finish || trunc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RIFF;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            tag_reg      <= '0;
            len_reg      <= '0;
            fmtc_reg     <= '0;
            chan_reg     <= '0;
            bits_reg     <= '0;
            rate_reg     <= '0;
            fmt_seen_reg <= 1'b0;
            low_reg      <= '0;
            left_reg     <= '0;
            half_reg     <= 1'b0;
        end
        else if (accept)
        begin
            if (eof)
            begin
                cnt_reg      <= '0;
                tag_reg      <= '0;
                len_reg      <= '0;
                fmtc_reg     <= '0;
                chan_reg     <= '0;
                bits_reg     <= '0;
                rate_reg     <= '0;
                fmt_seen_reg <= 1'b0;
                low_reg      <= '0;
                left_reg     <= '0;
                half_reg     <= 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_RIFF, PH_WAVE, PH_ID:
                    begin
                        tag_reg <= tag_new;
                        cnt_reg <= tag_end ? 4'd0 : cnt_reg + 4'd1;
                        if (phase_reg == PH_ID && tag_end)
                            len_reg <= '0;
                    end
                    PH_RSIZE:
                    begin
                        cnt_reg <= tag_end ? 4'd0 : cnt_reg + 4'd1;
                    end
                    PH_SIZE:
                    begin
                        if (!tag_end)
                        begin
                            cnt_reg <= cnt_reg + 4'd1;
                            unique case (cnt_reg[1:0])
                                2'd0:    len_reg[7:0]   <= b;
                                2'd1:    len_reg[15:8]  <= b;
                                default: len_reg[23:16] <= b;
                            endcase
                        end
                        else
                        begin
                            cnt_reg <= 4'd0;
                            priority if (tag_reg == TAG_FMT)
                                len_reg <= len_full;
                            else if (tag_reg == TAG_DATA)
                            begin
                                len_reg  <= {len_full[32:1], 1'b0};
                                half_reg <= 1'b0;
                            end
                            else
                                len_reg <= size_skip;
                        end
                    end
                    PH_FMT:
                    begin
                        cnt_reg <= cnt_reg + 4'd1;  // wraps to zero after the last field
                        unique case (cnt_reg)
                            4'd0:    fmtc_reg[7:0]   <= b;
                            4'd1:    fmtc_reg[15:8]  <= b;
                            4'd2:    chan_reg[7:0]   <= b;
                            4'd3:    chan_reg[15:8]  <= b;
                            4'd4:    rate_reg[7:0]   <= b;
                            4'd5:    rate_reg[15:8]  <= b;
                            4'd6:    rate_reg[23:16] <= b;
                            4'd7:    rate_reg[31:24] <= b;
                            4'd14:   bits_reg[7:0]   <= b;
                            4'd15:   bits_reg[15:8]  <= b;
                            default: ;
                        endcase
                        if (fmt_end)
                        begin
                            fmt_seen_reg <= 1'b1;
                            len_reg      <= fmt_skip;
                        end
                    end
                    PH_SKIP:
                    begin
                        if (len_reg != 33'd0)
                            len_reg <= len_reg - 33'd1;
                    end
                    PH_DATA:
                    begin
                        cnt_reg <= cnt_reg + 4'd1;
                        len_reg <= len_reg - 33'd1;
                        if (!cnt_reg[0])
                            low_reg <= b;
                        else if (chan_reg != 16'd1)
                        begin
                            if (!half_reg)
                            begin
                                left_reg <= smp;
                                half_reg <= 1'b1;
                            end
                            else
                                half_reg <= 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    a_eof_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && eof |=> phase_reg == PH_RIFF && !fmt_seen_reg)
        else $error("end of file did not return the parser to its start");

    a_fail_stops: assert property (@(posedge clk) disable iff (!rst_n)
        accept && fail && !eof |=> phase_reg == PH_IDLE)
        else $error("parser kept running after an error");

    a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> len_reg != 33'd0)
        else $error("data phase with no bytes left");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("result entry pushed into a full queue");

    a_header_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_RIFF || phase_reg == PH_RSIZE || phase_reg == PH_WAVE
         || phase_reg == PH_ID || phase_reg == PH_SIZE) |-> cnt_reg <= TAG_LAST)
        else $error("header byte count out of range");

endmodule

[rtl/wpm_queue.sv]
// ----------------------------------------------------------------------------
// wpm_queue
// Small FIFO of result entries between the parser and the output stage.
// ----------------------------------------------------------------------------
module wpm_queue #(
    parameter int DEPTH = wpm_pkg::QUEUE_DEPTH  // 2 or more
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  wpm_pkg::wpm_entry_t push_data,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output wpm_pkg::wpm_entry_t head_data
);
    import wpm_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    wpm_entry_t      mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

endmodule

[rtl/wpm_emit.sv]
// ----------------------------------------------------------------------------
// wpm_emit
// Output stage: splits queued entries into result words, one per ready cycle.
// ----------------------------------------------------------------------------
module wpm_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  wpm_pkg::wpm_entry_t head,
    output logic                pop,
    wpm_result_if.source        result
);
    import wpm_pkg::*;

    logic               valid_reg;
    logic               sent_reg;   // sample of the head entry already out
    wpm_kind_t          kind_reg;
    logic signed [15:0] sample_reg;
    logic [2:0]         code_reg;
    logic [31:0]        rate_reg;
    logic [1:0]         ch_reg;
    logic               last_reg;
    logic               load, send_sample;

    assign load        = !valid_reg || result.ready;
    assign send_sample = head.sample_v && !sent_reg;
    assign pop         = load && head_valid && !(send_sample && head.tail_v);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sent_reg  <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= head_valid;
            if (head_valid)
                sent_reg <= send_sample && head.tail_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && head_valid)
        begin
            if (send_sample)
            begin
                kind_reg   <= KIND_SAMPLE;
                sample_reg <= head.sample;
                code_reg   <= '0;
                rate_reg   <= '0;
                ch_reg     <= '0;
                last_reg   <= !head.tail_v;
            end
            else
            begin
                kind_reg   <= head.tail_err ? KIND_ERROR : KIND_FINISH;
                sample_reg <= '0;
                code_reg   <= head.code;
                rate_reg   <= head.rate;
                ch_reg     <= head.channels;
                last_reg   <= 1'b1;
            end
        end
    end

    assign result.valid           = valid_reg;
    assign result.result_kind     = kind_reg;
    assign result.mono_sample     = sample_reg;
    assign result.error_code      = code_reg;
    assign result.sample_rate_out = rate_reg;
    assign result.channel_count   = ch_reg;
    assign result.last_in_run     = last_reg;

endmodule

[bench/tb_wav_pcm16_parser_mono_downmix.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wav_pcm16_parser_mono_downmix
// Feeds whole WAV files byte by byte: a table of hand-made files for tag and
// format errors, odd sizes, peak samples and truncation, then random files,
// mostly well formed with some broken ones and noise. A parser model in the
// bench predicts every result word, which is checked field by field.
// ----------------------------------------------------------------------------
module tb_wav_pcm16_parser_mono_downmix;
    import wpm_pkg::*;

    localparam int TOTAL_BYTES = 1350;
    localparam logic [31:0] TAG_LIST = 32'h4C49_5354;
    // code field reads zero on samples and finish words
    localparam wpm_err_t CODE_NONE = ERR_NOT_RIFF;
    localparam logic [15:0] PEAK_WORDS [12] = '{
        16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF,
        16'hFFFF, 16'h0000, 16'h0001, 16'h0000, 16'h7FFF, 16'h8001
    };

    typedef struct packed {
        wpm_kind_t   kind;
        logic [15:0] sample;
        wpm_err_t    code;
        logic [31:0] rate;
        logic [1:0]  chans;
        logic        last;
    } wav_word_t;

    typedef struct packed {
        logic [31:0] riff_tag;
        logic [31:0] wave_tag;
        logic        junk_on;
        logic [31:0] junk_len;
        int          fmt_len;     // below zero: no fmt chunk
        logic        fmt_twice;   // a bogus fmt chunk comes first
        logic [15:0] fmt_format;
        logic [15:0] fmt_chans;
        logic [15:0] fmt_bits;
        logic [31:0] fmt_rate;
        logic [31:0] data_len;
        logic        peaks;
        int          keep;        // bytes kept, zero all, below zero random
        int          trailer;
        int          noise_len;
    } wav_recipe_t;

    typedef enum logic [4:0] {
        DC_BAD_RIFF, DC_BAD_WAVE, DC_NO_FMT, DC_CHECK_PCM, DC_CHECK_BITS,
        DC_NO_CHANNELS, DC_MANY_CHANNELS, DC_MONO_PEAKS, DC_STEREO_PEAKS,
        DC_ODD_DATA, DC_EMPTY_DATA, DC_TINY_DATA, DC_SHORT_FMT, DC_LONG_FMT,
        DC_CUT_IN_DATA, DC_CUT_IN_SKIP, DC_CUT_IN_FMT, DC_CUT_IN_TAG,
        DC_ONE_BYTE, DC_TRAILER
    } dir_case_t;

    typedef struct packed {
        dir_case_t which;
        logic      typed;
        wpm_kind_t kind;
        wpm_err_t  code;
    } dir_row_t;

    localparam dir_row_t PLAN [20] = '{
        '{DC_BAD_RIFF,      1'b1, KIND_ERROR,  ERR_NOT_RIFF},
        '{DC_BAD_WAVE,      1'b1, KIND_ERROR,  ERR_NOT_WAVE},
        '{DC_NO_FMT,        1'b1, KIND_ERROR,  ERR_DATA_BEFORE_FMT},
        '{DC_CHECK_PCM,     1'b1, KIND_ERROR,  ERR_NOT_PCM},
        '{DC_CHECK_BITS,    1'b1, KIND_ERROR,  ERR_NOT_16BIT},
        '{DC_NO_CHANNELS,   1'b1, KIND_ERROR,  ERR_BAD_CHANNELS},
        '{DC_MANY_CHANNELS, 1'b1, KIND_ERROR,  ERR_BAD_CHANNELS},
        '{DC_MONO_PEAKS,    1'b0, KIND_FINISH, CODE_NONE},
        '{DC_STEREO_PEAKS,  1'b0, KIND_FINISH, CODE_NONE},
        '{DC_ODD_DATA,      1'b1, KIND_FINISH, CODE_NONE},
        '{DC_EMPTY_DATA,    1'b1, KIND_FINISH, CODE_NONE},
        '{DC_TINY_DATA,     1'b1, KIND_FINISH, CODE_NONE},
        '{DC_SHORT_FMT,     1'b0, KIND_FINISH, CODE_NONE},
        '{DC_LONG_FMT,      1'b0, KIND_FINISH, CODE_NONE},
        '{DC_CUT_IN_DATA,   1'b1, KIND_ERROR,  ERR_TRUNCATED},
        '{DC_CUT_IN_SKIP,   1'b1, KIND_ERROR,  ERR_TRUNCATED},
        '{DC_CUT_IN_FMT,    1'b1, KIND_ERROR,  ERR_TRUNCATED},
        '{DC_CUT_IN_TAG,    1'b1, KIND_ERROR,  ERR_TRUNCATED},
        '{DC_ONE_BYTE,      1'b1, KIND_ERROR,  ERR_TRUNCATED},
        '{DC_TRAILER,       1'b1, KIND_FINISH, CODE_NONE}
    };

    logic clk = 1'b0;
    logic rst_n;

    wpm_byte_if   wav ();
    wpm_result_if result ();

    wav_pcm16_parser_mono_downmix dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .wav    (wav),
        .result (result)
    );

    always #5 clk = ~clk;

    wav_word_t   want_q [$];
    logic [7:0]  file_q [$];
    int          mismatches = 0;
    int          words_seen = 0;
    int          taken = 0;
    int unsigned cyc = 0;

    // parser model state
    wpm_phase_t  ph;
    logic [31:0] cnt;
    logic [31:0] tag_sr;
    logic [32:0] clen;
    logic [15:0] f_code;
    logic [15:0] f_chans;
    logic [15:0] f_bits;
    logic [31:0] f_rate;
    logic        have_fmt;
    logic [7:0]  lo_byte;
    logic [15:0] left_word;
    logic        half;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t, word %0d: %s", $time, words_seen, msg);
    endtask

    function automatic void parser_reset();
        ph = PH_RIFF;
        cnt = '0;
        tag_sr = '0;
        clen = '0;
        f_code = '0;
        f_chans = '0;
        f_bits = '0;
        f_rate = '0;
        have_fmt = 1'b0;
        lo_byte = '0;
        left_word = '0;
        half = 1'b0;
    endfunction

    function automatic void push_word(wpm_kind_t k, logic [15:0] s, wpm_err_t c,
                                      logic [31:0] r, logic [1:0] ch);
        wav_word_t w;
        w.kind = k;
        w.sample = s;
        w.code = c;
        w.rate = r;
        w.chans = ch;
        w.last = 1'b0;
        want_q.push_back(w);
    endfunction

    function automatic void fail_file(wpm_err_t c);
        push_word(KIND_ERROR, 16'h0000, c, 32'd0, 2'd0);
        ph = PH_IDLE;
    endfunction

    function automatic void finish_file();
        push_word(KIND_FINISH, 16'h0000, CODE_NONE, f_rate, f_chans[1:0]);
        ph = PH_IDLE;
    endfunction

    function automatic void skip_bytes(logic [32:0] n);
        cnt = '0;
        clen = n;
        ph = (n == 33'd0) ? PH_ID : PH_SKIP;
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic eof);
        int                 n0;
        logic [15:0]        smp;
        logic signed [16:0] sum;
        n0 = want_q.size();
        case (ph)
            PH_RIFF, PH_WAVE, PH_ID:
            begin
                tag_sr = {tag_sr[23:0], b};
                cnt = cnt + 1;
                if (cnt >= 4)
                begin
                    cnt = '0;
                    if (ph == PH_RIFF)
                    begin
                        if (tag_sr != TAG_RIFF) fail_file(ERR_NOT_RIFF);
                        else ph = PH_RSIZE;
                    end
                    else if (ph == PH_WAVE)
                    begin
                        if (tag_sr != TAG_WAVE) fail_file(ERR_NOT_WAVE);
                        else ph = PH_ID;
                    end
                    else
                    begin
                        clen = '0;
                        ph = PH_SIZE;
                    end
                end
            end
            PH_RSIZE:
            begin
                cnt = cnt + 1;
                if (cnt >= 4)
                begin
                    cnt = '0;
                    ph = PH_WAVE;
                end
            end
            PH_SIZE:
            begin
                clen = clen | ({25'd0, b} << (8 * cnt[1:0]));
                cnt = cnt + 1;
                if (cnt >= 4)
                begin
                    cnt = '0;
                    if (tag_sr == TAG_FMT)
                        ph = PH_FMT;
                    else if (tag_sr == TAG_DATA)
                    begin
                        if (!have_fmt) fail_file(ERR_DATA_BEFORE_FMT);
                        else if (f_code != FORMAT_PCM) fail_file(ERR_NOT_PCM);
                        else if (f_bits != BITS_16) fail_file(ERR_NOT_16BIT);
                        else if (f_chans < 1 || f_chans > 2) fail_file(ERR_BAD_CHANNELS);
                        else
                        begin
                            half = 1'b0;
                            if (clen[32:1] == '0) finish_file();
                            else ph = PH_DATA;
                        end
                    end
                    else
                        skip_bytes(clen + {32'd0, clen[0]});
                end
            end
            PH_FMT:
            begin
                case (cnt)
                    0, 1:       f_code[8 * cnt[0] +: 8] = b;
                    2, 3:       f_chans[8 * cnt[0] +: 8] = b;
                    4, 5, 6, 7: f_rate[8 * cnt[1:0] +: 8] = b;
                    14, 15:     f_bits[8 * cnt[0] +: 8] = b;
                    default:    ;
                endcase
                cnt = cnt + 1;
                if (cnt >= 16)
                begin
                    have_fmt = 1'b1;
                    // parse 16 bytes even on a short chunk, then skip rest and pad
                    skip_bytes(((clen > 33'd16) ? clen - 33'd16 : 33'd0) + {32'd0, clen[0]});
                end
            end
            PH_SKIP:
            begin
                if (clen != '0) clen = clen - 1;
                if (clen == '0)
                begin
                    cnt = '0;
                    ph = PH_ID;
                end
            end
            PH_DATA:
            begin
                if (!cnt[0])
                    lo_byte = b;
                else
                begin
                    smp = {b, lo_byte};
                    if (f_chans == 16'd1)
                        push_word(KIND_SAMPLE, smp, CODE_NONE, 32'd0, 2'd0);
                    else if (!half)
                    begin
                        left_word = smp;
                        half = 1'b1;
                    end
                    else
                    begin
                        // arithmetic shift of the full sum gives the floor
                        sum = $signed({left_word[15], left_word}) + $signed({smp[15], smp});
                        push_word(KIND_SAMPLE, sum[16:1], CODE_NONE, 32'd0, 2'd0);
                        half = 1'b0;
                    end
                end
                cnt = cnt + 1;
                if ({1'b0, cnt} >= {clen[32:1], 1'b0}) finish_file();
            end
            default: ph = PH_IDLE;
        endcase
        if (eof)
        begin
            if (ph != PH_IDLE) fail_file(ERR_TRUNCATED);
            parser_reset();
        end
        if (want_q.size() > n0) want_q[want_q.size() - 1].last = 1'b1;
    endfunction

    function automatic void put_le(logic [31:0] v, int n);
        for (int k = 0; k < n; k++) file_q.push_back(v[8 * k +: 8]);
    endfunction

    function automatic void put_tag(logic [31:0] t);
        for (int k = 3; k >= 0; k--) file_q.push_back(t[8 * k +: 8]);
    endfunction

    function automatic void put_noise(int n);
        for (int k = 0; k < n; k++) file_q.push_back(8'($urandom));
    endfunction

    function automatic void build_wav(wav_recipe_t rc);
        int          body;
        int          cut;
        logic [15:0] pw;
        file_q.delete();
        if (rc.noise_len > 0)
        begin
            put_noise(rc.noise_len);
            return;
        end
        put_tag(rc.riff_tag);
        put_le($urandom, 4);
        put_tag(rc.wave_tag);
        if (rc.junk_on)
        begin
            put_tag(TAG_LIST);
            put_le(rc.junk_len, 4);
            body = (rc.junk_len > 300) ? 48 : int'(rc.junk_len) + int'(rc.junk_len[0]);
            put_noise(body);
        end
        if (rc.fmt_twice)
        begin
            put_tag(TAG_FMT);
            put_le(32'd16, 4);
            put_le(32'd3, 2);
            put_le(32'd7, 2);
            put_noise(10);
            put_le(32'd8, 2);
        end
        if (rc.fmt_len >= 0)
        begin
            put_tag(TAG_FMT);
            put_le(rc.fmt_len, 4);
            put_le(32'(rc.fmt_format), 2);
            put_le(32'(rc.fmt_chans), 2);
            put_le(rc.fmt_rate, 4);
            put_noise(6);
            put_le(32'(rc.fmt_bits), 2);
            put_noise(((rc.fmt_len > 16) ? rc.fmt_len - 16 : 0) + rc.fmt_len % 2);
        end
        put_tag(TAG_DATA);
        put_le(rc.data_len, 4);
        body = (rc.data_len > 1024) ? 64 : int'(rc.data_len) + int'(rc.data_len[0]);
        for (int k = 0; k < body; k++)
        begin
            pw = PEAK_WORDS[(k / 2) % 12];
            if (rc.peaks) file_q.push_back(k[0] ? pw[15:8] : pw[7:0]);
            else file_q.push_back(8'($urandom));
        end
        put_noise(rc.trailer);
        cut = (rc.keep < 0) ? int'($urandom_range(file_q.size() - 1, 1)) : rc.keep;
        if (cut > 0)
            while (file_q.size() > cut) void'(file_q.pop_back());
    endfunction

    function automatic wav_recipe_t base_recipe();
        wav_recipe_t rc;
        rc.riff_tag = TAG_RIFF;
        rc.wave_tag = TAG_WAVE;
        rc.junk_on = 1'b0;
        rc.junk_len = 32'd0;
        rc.fmt_len = 16;
        rc.fmt_twice = 1'b0;
        rc.fmt_format = FORMAT_PCM;
        rc.fmt_chans = 16'd1;
        rc.fmt_bits = BITS_16;
        rc.fmt_rate = 32'd44100;
        rc.data_len = 32'd8;
        rc.peaks = 1'b0;
        rc.keep = 0;
        rc.trailer = 0;
        rc.noise_len = 0;
        return rc;
    endfunction

    function automatic wav_recipe_t directed_recipe(dir_case_t which);
        wav_recipe_t rc;
        rc = base_recipe();
        case (which)
            DC_BAD_RIFF:
            begin
                rc.riff_tag = 32'h5249_4658;
                rc.trailer = 3;
            end
            DC_BAD_WAVE:      rc.wave_tag = 32'h5741_5646;
            DC_NO_FMT:        rc.fmt_len = -1;
            DC_CHECK_PCM:
            begin
                rc.fmt_format = 16'd3;
                rc.fmt_bits = 16'd8;
                rc.fmt_chans = 16'd0;
            end
            DC_CHECK_BITS:
            begin
                rc.fmt_bits = 16'd8;
                rc.fmt_chans = 16'd0;
            end
            DC_NO_CHANNELS:   rc.fmt_chans = 16'd0;
            DC_MANY_CHANNELS: rc.fmt_chans = 16'hFFFF;
            DC_MONO_PEAKS:
            begin
                rc.peaks = 1'b1;
                rc.data_len = 32'd24;
                rc.fmt_rate = 32'hFFFF_FFFF;
            end
            DC_STEREO_PEAKS:
            begin
                // six frames and a lone left sample
                rc.fmt_chans = 16'd2;
                rc.peaks = 1'b1;
                rc.data_len = 32'd26;
                rc.fmt_rate = 32'd0;
            end
            DC_ODD_DATA:      rc.data_len = 32'd7;
            DC_EMPTY_DATA:    rc.data_len = 32'd0;
            DC_TINY_DATA:
            begin
                rc.data_len = 32'd1;
                rc.fmt_chans = 16'd2;
            end
            DC_SHORT_FMT:
            begin
                rc.fmt_len = 13;
                rc.junk_on = 1'b1;
                rc.junk_len = 32'd3;
                rc.fmt_twice = 1'b1;
                rc.fmt_chans = 16'd2;
                rc.data_len = 32'd12;
            end
            DC_LONG_FMT:
            begin
                rc.fmt_len = 18;
                rc.junk_on = 1'b1;
                rc.junk_len = 32'd0;
            end
            DC_CUT_IN_DATA:   rc.data_len = 32'hFFFF_FFFF;
            DC_CUT_IN_SKIP:
            begin
                rc.junk_on = 1'b1;
                rc.junk_len = 32'hFFFF_FFFF;
            end
            DC_CUT_IN_FMT:    rc.keep = 30;
            DC_CUT_IN_TAG:    rc.keep = 2;
            DC_ONE_BYTE:      rc.keep = 1;
            DC_TRAILER:       rc.trailer = 5;
            default:          ;
        endcase
        return rc;
    endfunction

    function automatic wav_recipe_t random_recipe();
        wav_recipe_t rc;
        int          pick;
        rc = base_recipe();
        rc.junk_on = ($urandom_range(99) < 30);
        rc.junk_len = ($urandom_range(99) < 10) ? 32'hFFFF_FFFF - $urandom_range(3, 0)
                                                : 32'($urandom_range(9, 0));
        pick = $urandom_range(99);
        if (pick < 15) rc.fmt_len = $urandom_range(15, 0);
        else if (pick < 30) rc.fmt_len = $urandom_range(30, 17);
        rc.fmt_twice = ($urandom_range(99) < 10);
        rc.fmt_chans = 16'($urandom_range(2, 1));
        rc.fmt_rate = $urandom;
        rc.data_len = ($urandom_range(99) < 10) ? 32'($urandom_range(200, 49))
                                                : 32'($urandom_range(48, 0));
        rc.peaks = ($urandom_range(99) < 15);
        rc.trailer = ($urandom_range(99) < 20) ? int'($urandom_range(4, 1)) : 0;
        // about a third of the files are broken in one way
        pick = $urandom_range(99);
        if (pick < 6) rc.noise_len = $urandom_range(12, 1);
        else if (pick < 9) rc.riff_tag[$urandom_range(31, 0)] ^= 1'b1;
        else if (pick < 12) rc.wave_tag[$urandom_range(31, 0)] ^= 1'b1;
        else if (pick < 15) rc.fmt_len = -1;
        else if (pick < 18)
        begin
            rc.fmt_format = 16'($urandom);
            if (rc.fmt_format == FORMAT_PCM) rc.fmt_format = 16'd0;
        end
        else if (pick < 21)
        begin
            rc.fmt_bits = 16'($urandom);
            if (rc.fmt_bits == BITS_16) rc.fmt_bits = 16'd24;
        end
        else if (pick < 24)
            rc.fmt_chans = ($urandom_range(1, 0) != 0) ? 16'd0 : 16'($urandom_range(65535, 3));
        else if (pick < 30) rc.keep = -1;
        else if (pick < 32) rc.data_len = 32'hFFFF_FFFF - $urandom_range(1, 0);
        return rc;
    endfunction

    task automatic send_file(input logic [7:0] q[$], input logic typed,
                             input wpm_kind_t kind, input wpm_err_t code);
        int n0;
        foreach (q[i])
        begin
            while (!(taken >= 500 && taken < 800) && $urandom_range(99) < 11)
            begin
                wav.valid <= 1'b0;
                @(posedge clk);
            end
            wav.valid <= 1'b1;
            wav.data_byte <= q[i];
            wav.end_of_file <= (i == q.size() - 1);
            @(posedge clk);
            while (!wav.ready) @(posedge clk);
            taken++;
            n0 = want_q.size();
            predict_byte(q[i], i == q.size() - 1);
            if (typed)
                for (int k = n0; k < want_q.size(); k++)
                    if (want_q[k].kind != KIND_SAMPLE)
                    begin
                        want_q[k].kind = kind;
                        want_q[k].code = code;
                    end
        end
    endtask

    task automatic pause_for_results();
        if (want_q.size() != 0)
        begin
            wav.valid <= 1'b0;
            while (want_q.size() != 0) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        result.ready <= (cyc >= 600 && cyc < 1000) || ($urandom_range(99) >= 11);
    end

    always @(posedge clk)
    begin : watch_results
        wav_word_t w;
        if (rst_n && result.valid && result.ready)
        begin
            if (want_q.size() == 0)
                report_mismatch($sformatf("unexpected word, kind %0d", result.result_kind));
            else
            begin
                w = want_q.pop_front();
                if (result.result_kind !== w.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", result.result_kind, w.kind));
                if (result.mono_sample !== w.sample)
                    report_mismatch($sformatf("sample %h, want %h", result.mono_sample, w.sample));
                if (result.error_code !== w.code)
                    report_mismatch($sformatf("code %0d, want %0d", result.error_code, w.code));
                if (result.sample_rate_out !== w.rate)
                    report_mismatch($sformatf("rate %h, want %h", result.sample_rate_out, w.rate));
                if (result.channel_count !== w.chans)
                    report_mismatch($sformatf("channels %0d, want %0d",
                                              result.channel_count, w.chans));
                if (result.last_in_run !== w.last)
                    report_mismatch($sformatf("last %b, want %b", result.last_in_run, w.last));
            end
            words_seen++;
        end
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : run
        int files;
        int guard;
        parser_reset();
        wav.valid = 1'b0;
        wav.data_byte = 8'h00;
        wav.end_of_file = 1'b0;
        result.ready = 1'b0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PLAN[r])
        begin
            build_wav(directed_recipe(PLAN[r].which));
            send_file(file_q, PLAN[r].typed, PLAN[r].kind, PLAN[r].code);
        end
        pause_for_results();

        files = 0;
        while (taken < TOTAL_BYTES)
        begin
            build_wav(random_recipe());
            send_file(file_q, 1'b0, KIND_FINISH, CODE_NONE);
            files++;
            if (files % 7 == 6) pause_for_results();
        end
        wav.valid <= 1'b0;

        for (guard = 0; guard < 20000 && want_q.size() != 0; guard++) @(posedge clk);
        repeat (8) @(posedge clk);
        if (want_q.size() != 0)
            report_mismatch($sformatf("%0d expected words never arrived", want_q.size()));
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
